[hw/rtl/mcpq_pkg.sv]
package mcpq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int PACKET_BYTES = 4;
   localparam int BEAT_WIDTH = $clog2(PACKET_BYTES);
   localparam int CHECK_WIDTH = 7;

   localparam logic [1:0] MODE_COMMAND  = 2'd0;
   localparam logic [1:0] MODE_RAW      = 2'd1;
   localparam logic [1:0] MODE_TX_READY = 2'd2;

   localparam logic [1:0] KIND_STORED = 2'd0;
   localparam logic [1:0] KIND_FULL   = 2'd1;
   localparam logic [1:0] KIND_TX     = 2'd2;
   localparam logic [1:0] KIND_EMPTY  = 2'd3;

   // byte 0 of the packet sits in the top element
   typedef logic [PACKET_BYTES-1:0][7:0] packet_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] address_byte;
      logic [7:0] command_byte;
      logic [7:0] speed_byte;
      logic [7:0] check_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      packet_type packet;
   } store_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } store_status_type;

   typedef struct packed {
      logic       start;
      logic [1:0] kind;
   } emit_load_type;

endpackage

[hw/rtl/mcpq_store.sv]
module mcpq_store import mcpq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  store_cmd_type    cmd,
   output store_status_type status,
   output packet_type       rd_data
);

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(QUEUE_DEPTH);

   packet_type mem [QUEUE_DEPTH];
   packet_type rd_data_ff;

   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (cmd.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (cmd.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // read data holds until the next pop
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_ptr_ff] <= cmd.packet;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign rd_data      = rd_data_ff;

endmodule

[hw/rtl/mcpq_emit.sv]
module mcpq_emit import mcpq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  emit_load_type load,
   input  packet_type    rd_data,
   output logic          free,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam logic [BEAT_WIDTH-1:0] LAST_BEAT = BEAT_WIDTH'(PACKET_BYTES - 1);

   logic                  valid_ff, valid_in;
   logic [1:0]            kind_ff, kind_in;
   logic [BEAT_WIDTH-1:0] beat_ff, beat_in;
   logic                  accept;
   logic                  is_last;
   logic [BEAT_WIDTH-1:0] byte_index;

   assign accept     = valid_ff && !rsp_stall;
   assign is_last    = (kind_ff != KIND_TX) || (beat_ff == LAST_BEAT);
   assign free       = !valid_ff || (accept && is_last);
   assign byte_index = LAST_BEAT - beat_ff;

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      beat_in  = beat_ff;
      if (accept) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 1'b1;
         end
      end
      if (load.start) begin
         valid_in = 1'b1;
         kind_in  = load.kind;
         beat_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      kind_ff <= kind_in;
      beat_ff <= beat_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_data.kind    = kind_ff;
   assign rsp_data.tx_byte = (kind_ff == KIND_TX) ? rd_data[byte_index] : 8'h00;
   assign rsp_data.last    = is_last;

endmodule

[hw/rtl/motor_command_packet_queue.sv]
// A request is registered at acceptance and dispatched once the result side is
// free; results leave through the single result register. A transmit-ready
// request with a stored packet gives four results, one per cycle while rsp_stall
// is low; store requests and empty pops give one result, the unused mode none.
// Reset clears pointers, count and valid flags; packet storage is not cleared.
module motor_command_packet_queue import mcpq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic             in_valid_ff, in_valid_in;
   req_type          in_ff;
   logic             is_store, is_pop, dispatch, emit_free;
   logic [9:0]       sum;
   logic [7:0]       check;
   store_cmd_type    cmd;
   store_status_type status;
   emit_load_type    load;
   packet_type       rd_data;

   assign is_store = (in_ff.mode == MODE_COMMAND) || (in_ff.mode == MODE_RAW);
   assign is_pop   = (in_ff.mode == MODE_TX_READY);
   // unused mode drops without waiting on the result side
   assign dispatch = in_valid_ff && (emit_free || !(is_store || is_pop));

   assign sum   = {2'b00, in_ff.address_byte} + {2'b00, in_ff.command_byte}
                + {2'b00, in_ff.speed_byte};
   assign check = (in_ff.mode == MODE_COMMAND) ? {1'b0, sum[CHECK_WIDTH-1:0]}
                                               : in_ff.check_byte;

   assign cmd.push   = dispatch && is_store && !status.full;
   assign cmd.pop    = dispatch && is_pop && !status.empty;
   assign cmd.packet = {in_ff.address_byte, in_ff.command_byte, in_ff.speed_byte, check};

   assign load.start = dispatch && (is_store || is_pop);
   assign load.kind  = is_store ? (status.full ? KIND_FULL : KIND_STORED)
                                : (status.empty ? KIND_EMPTY : KIND_TX);

   assign req_stall = in_valid_ff && !dispatch;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (dispatch) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   mcpq_store #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .rd_data (rd_data)
   );

   mcpq_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .rd_data   (rd_data),
      .free      (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sim/motor_packet_checker.sv]
module motor_packet_checker import mcpq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   packet_type packet_slots [QUEUE_DEPTH];
   int         oldest_slot;
   int         free_slot;
   int         stored_count;
   int         error_total;
   rsp_type    pending_results [$];
   rsp_type    awaited;

   function automatic void predict_packet_results(input req_type request);
      packet_type packet;
      logic [9:0] byte_sum;
      case (request.mode)
         MODE_COMMAND, MODE_RAW: begin
            packet = {request.address_byte, request.command_byte,
                      request.speed_byte, request.check_byte};
            if (request.mode == MODE_COMMAND) begin
               // replace the fourth byte with the 7-bit sum
               byte_sum = 10'(request.address_byte) + 10'(request.command_byte)
                        + 10'(request.speed_byte);
               packet[0] = 8'(byte_sum[CHECK_WIDTH-1:0]);
            end
            if (stored_count >= QUEUE_DEPTH) begin
               pending_results.push_back(rsp_type'{KIND_FULL, 8'h00, 1'b1});
            end else begin
               packet_slots[free_slot] = packet;
               free_slot = (free_slot == QUEUE_DEPTH - 1) ? 0 : free_slot + 1;
               stored_count++;
               pending_results.push_back(rsp_type'{KIND_STORED, 8'h00, 1'b1});
            end
         end
         MODE_TX_READY: begin
            if (stored_count == 0) begin
               pending_results.push_back(rsp_type'{KIND_EMPTY, 8'h00, 1'b1});
            end else begin
               packet = packet_slots[oldest_slot];
               oldest_slot = (oldest_slot == QUEUE_DEPTH - 1) ? 0 : oldest_slot + 1;
               stored_count--;
               // byte 0 goes out first
               for (int i = PACKET_BYTES - 1; i >= 0; i--) begin
                  pending_results.push_back(rsp_type'{KIND_TX, packet[i], i == 0});
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         oldest_slot = 0;
         free_slot = 0;
         stored_count = 0;
         error_total = 0;
         pending_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_packet_results(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: kind %0d, tx_byte %0h, last %0b",
                      rsp_data.kind, rsp_data.tx_byte, rsp_data.last);
               error_total++;
            end else begin
               awaited = pending_results.pop_front();
               if (rsp_data.kind !== awaited.kind) begin
                  $error("kind: expected %0d, actual %0d", awaited.kind, rsp_data.kind);
                  error_total++;
               end
               if (rsp_data.tx_byte !== awaited.tx_byte) begin
                  $error("tx_byte: expected %0h, actual %0h",
                         awaited.tx_byte, rsp_data.tx_byte);
                  error_total++;
               end
               if (rsp_data.last !== awaited.last) begin
                  $error("last: expected %0b, actual %0b", awaited.last, rsp_data.last);
                  error_total++;
               end
            end
         end
      end
      failures <= error_total;
      pending <= pending_results.size();
   end

endmodule

[sim/motor_command_packet_queue_test.sv]
module motor_command_packet_queue_test;
   import mcpq_pkg::*;

   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam int LONG_HOLD = 200;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS = 40;
   localparam int PHASE_COUNT = 6;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int   failures;
   int   pending;
   int   stall_cycles;
   int   hold_requests = 0;
   int   holds_done = 0;
   logic hold_active = 1'b0;

   always #1 clock = ~clock;

   motor_command_packet_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   motor_packet_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type random_request(input int store_pct);
      req_type request;
      int      pick;
      request.address_byte = 8'($urandom);
      request.command_byte = 8'($urandom);
      request.speed_byte = 8'($urandom);
      request.check_byte = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         request.mode = MODE_IGNORED;
      end else if (pick < 5 + store_pct * 95 / 100) begin
         request.mode = $urandom_range(0, 1) ? MODE_RAW : MODE_COMMAND;
      end else begin
         request.mode = MODE_TX_READY;
      end
      return request;
   endfunction

   // hold the request until accepted, then idle for the given gap
   task automatic send_request(input req_type request, input int gap);
      req_valid <= 1'b1;
      req_data <= request;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : response_side
      int pick;
      int span;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active = 1'b0;
            holds_done++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               rsp_stall <= 1'b0;
               span = $urandom_range(1, 8);
            end else if (pick < 85) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(1, 3);
            end else if (pick < 95) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(10, 40);
            end else begin
               rsp_stall <= 1'b0;
               span = $urandom_range(30, 60);
            end
            repeat (span) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : request_side
      int      store_bias [PHASE_COUNT];
      int      counted;
      req_type request;
      store_bias = '{80, 15, 55, 90, 10, 50};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // pop on an empty queue
      send_request(req_type'{MODE_TX_READY, 8'h00, 8'hff, 8'h00, 8'hff}, idle_gap());
      // fill all slots, extremes first
      send_request(req_type'{MODE_COMMAND, 8'h00, 8'h00, 8'h00, 8'h00}, idle_gap());
      send_request(req_type'{MODE_COMMAND, 8'hff, 8'hff, 8'hff, 8'hff}, idle_gap());
      send_request(req_type'{MODE_RAW, 8'hff, 8'hff, 8'hff, 8'hff}, idle_gap());
      send_request(req_type'{MODE_RAW, 8'h00, 8'h00, 8'h00, 8'h00}, idle_gap());
      send_request(req_type'{MODE_COMMAND, 8'h7f, 8'h7f, 8'h7f, 8'hff}, idle_gap());
      for (int i = 0; i < 11; i++) begin
         request = random_request(100);
         if (request.mode == MODE_IGNORED) request.mode = MODE_RAW;
         send_request(request, idle_gap());
      end
      // refused on a full queue
      send_request(req_type'{MODE_RAW, 8'ha5, 8'h5a, 8'hc3, 8'h3c}, idle_gap());
      send_request(req_type'{MODE_IGNORED, 8'hff, 8'hff, 8'hff, 8'hff}, idle_gap());
      for (int i = 0; i < 4; i++) begin
         send_request(req_type'{MODE_TX_READY, 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom)}, idle_gap());
      end
      wait_drained();

      // back up the queue behind a stalled receiver
      hold_requests++;
      do @(posedge clock); while (!hold_active);
      for (int i = 0; i < 30; i++) begin
         send_request(random_request(50), 0);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            request = random_request(store_bias[phase]);
            send_request(request, (phase == 2) ? 0 : idle_gap());
            if (request.mode != MODE_IGNORED) counted++;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
